>>> sv/assert_macros.svh
// Assertion macros shared by the stack RTL; they sample on clk and mute during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every sampled edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/lifo_rev_pkg.sv
// Shared constants, codes and controller/datapath types for the reversible stack.
`timescale 1ns / 1ps
package lifo_rev_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = 7;
  localparam int CFG_W      = 7;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI
  } state_t;

  typedef struct packed {
    logic accept;
    logic rev_start;
    logic rd_lo;
    logic rd_hi;
    logic wr_lo;
    logic wr_hi;
    logic rev_done;
  } cmd_t;

  typedef struct packed {
    logic rev_long;
    logic rev_last;
  } stat_t;

endpackage

>>> sv/lifo_rev_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lifo_rev_ram #(
  parameter int WIDTH   = 32,
  parameter int DEPTH_P = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH_P];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/lifo_rev_ctrl.sv
// Controller FSM: request acceptance and the pairwise swap sequence of a reverse.
`timescale 1ns / 1ps
module lifo_rev_ctrl import lifo_rev_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] in_req_type,
  input  stat_t            stat,
  output cmd_t             cmd,
  output logic             busy
);

  state_t state_r, state_nxt;
  logic   accept;
  logic   rev_start;

  assign accept    = start && (state_r == S_IDLE);
  assign rev_start = accept && (in_req_type == REQ_REVERSE) && stat.rev_long;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (rev_start) begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: state_nxt = S_RD_HI;
      S_RD_HI: state_nxt = S_WR_LO;
      S_WR_LO: state_nxt = S_WR_HI;
      S_WR_HI: state_nxt = stat.rev_last ? S_IDLE : S_RD_LO;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.accept    = accept;
    cmd.rev_start = rev_start;
    case (state_r)
      S_RD_LO: cmd.rd_lo = 1'b1;
      S_RD_HI: cmd.rd_hi = 1'b1;
      S_WR_LO: cmd.wr_lo = 1'b1;
      S_WR_HI: begin
        cmd.wr_hi    = 1'b1;
        cmd.rev_done = stat.rev_last;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> sv/lifo_rev_dp.sv
// Datapath: element RAM, fill count, capacity, swap pointers and result registers.
`timescale 1ns / 1ps
module lifo_rev_dp import lifo_rev_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]   in_push_value,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_pop_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_fill_count,
  output logic                out_is_empty,
  output logic                out_is_full
);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [ADDR_W-1:0]     lo_r, lo_nxt;
  logic [ADDR_W-1:0]     hi_r, hi_nxt;
  logic [ELEM_WIDTH-1:0] tmp_r, tmp_nxt;
  logic                  valid_r, valid_nxt;
  logic                  pop_sel_r, pop_sel_nxt;
  status_t               status_r, status_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ELEM_WIDTH-1:0] ram_rdata;
  logic [CNT_W-1:0]      cnt_m1;

  lifo_rev_ram #(
    .WIDTH   (ELEM_WIDTH),
    .DEPTH_P (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1        = count_r - CNT_W'(1);
  assign stat.rev_long = (count_r >= CNT_W'(2));
  // last pair once the pointers would meet or cross after this swap
  assign stat.rev_last = (({1'b0, lo_r} + (ADDR_W+1)'(2)) >= {1'b0, hi_r});

  // capacity is clamped to 1..DEPTH on write
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (CNT_W'(cfg_wdata) > CNT_W'(DEPTH)) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = CNT_W'(cfg_wdata);
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    valid_nxt   = 1'b0;
    pop_sel_nxt = 1'b0;
    status_nxt  = ST_DONE;
    ram_we      = 1'b0;
    ram_waddr   = count_r[ADDR_W-1:0];
    ram_wdata   = in_push_value[ELEM_WIDTH-1:0];
    ram_raddr   = lo_r;
    tmp_nxt     = cmd.rd_hi ? ram_rdata : tmp_r;

    if (cmd.accept) begin
      valid_nxt = !cmd.rev_start;
      case (in_req_type)
        REQ_PUSH: begin
          if (count_r >= cap_r) begin
            status_nxt = ST_OVERFLOW;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (count_r == '0) begin
            status_nxt = ST_UNDERFLOW;
          end else begin
            ram_raddr   = cnt_m1[ADDR_W-1:0];
            count_nxt   = cnt_m1;
            pop_sel_nxt = 1'b1;
          end
        end
        REQ_REVERSE: begin
          lo_nxt = '0;
          hi_nxt = cnt_m1[ADDR_W-1:0];
        end
        default: ;
      endcase
    end

    if (cmd.rd_lo) begin
      ram_raddr = lo_r;
    end
    if (cmd.rd_hi) begin
      ram_raddr = hi_r;
    end
    // ram_rdata holds the high entry during the low write
    if (cmd.wr_lo) begin
      ram_we    = 1'b1;
      ram_waddr = lo_r;
      ram_wdata = ram_rdata;
    end
    if (cmd.wr_hi) begin
      ram_we    = 1'b1;
      ram_waddr = hi_r;
      ram_wdata = tmp_r;
      lo_nxt    = lo_r + ADDR_W'(1);
      hi_nxt    = hi_r - ADDR_W'(1);
    end
    if (cmd.rev_done) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      cap_r     <= CNT_W'(DEPTH);
      valid_r   <= 1'b0;
      pop_sel_r <= 1'b0;
      status_r  <= ST_DONE;
    end else begin
      count_r   <= count_nxt;
      cap_r     <= cap_nxt;
      valid_r   <= valid_nxt;
      pop_sel_r <= pop_sel_nxt;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tmp_r <= tmp_nxt;
  end

  assign out_valid      = valid_r;
  assign out_pop_value  = pop_sel_r ? DATA_W'(ram_rdata) : '0;
  assign out_status     = status_r;
  assign out_fill_count = count_r;
  assign out_is_empty   = (count_r == '0);
  assign out_is_full    = (count_r >= cap_r);

endmodule

>>> sv/bounded_lifo_stack_with_reverse.sv
// Top level of the bounded stack with push, pop and in-place reverse.
// Push/pop: result in the cycle after transfer, a new request every cycle when idle.
// Reverse of n elements: busy while floor(n/2) pairs swap, one RAM access per cycle.
// Synchronous active-low reset empties the stack and sets capacity to full depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bounded_lifo_stack_with_reverse import lifo_rev_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [DATA_W-1:0]   in_push_value,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output logic                out_valid,
  output logic [DATA_W-1:0]   out_pop_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]    out_fill_count,
  output logic                out_is_empty,
  output logic                out_is_full
);

  cmd_t  cmd;
  stat_t stat;

  lifo_rev_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  lifo_rev_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_push_value  (in_push_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_pop_value  (out_pop_value),
    .out_status     (out_status),
    .out_fill_count (out_fill_count),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

  `ASSERT_ALWAYS(a_fill_bound, out_fill_count <= CNT_W'(DEPTH), "fill count above depth")
  `ASSERT_NEXT(a_quick_result, start && !busy && (in_req_type != REQ_REVERSE), out_valid, "push/pop transfer without result")
  `ASSERT_SAME(a_walk_silent, $rose(busy), !out_valid, "result while reverse walk starts")
  `ASSERT_SAME(a_walk_result, $fell(busy), out_valid, "reverse walk ended without result")

endmodule
